// File: sv/cehbt_pkg.sv
package cehbt_pkg;

    localparam int MAX_WIDTH_DEF        = 1024;
    localparam int MAX_HEIGHT_DEF       = 1024;
    localparam int FRAME_INDEX_BITS_DEF = 16;

    localparam int PIX_W      = 8;
    localparam int FW_W       = 11;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int ROW_SUM_W = 20;
    localparam int HIT_W     = 11;
    localparam int FRAC_W    = 8;
    localparam int AVG_W     = 18;
    localparam int IAVG_W    = 24;
    localparam int ISUM_W    = 16;
    localparam int ICNT_W    = 16;

    localparam int DVD_W = ROW_SUM_W + FRAC_W;
    localparam int DVS_W = 16;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd4;

    localparam logic [PIX_W-1:0] TOLERANCE_RESET   = 8'd30;
    localparam logic [FW_W-1:0]  FRAME_WIDTH_RESET = 11'd1024;

    typedef struct packed {
        logic [PIX_W-1:0] target_red;
        logic [PIX_W-1:0] target_green;
        logic [PIX_W-1:0] target_blue;
        logic [PIX_W-1:0] tolerance;
        logic [FW_W-1:0]  frame_width;
    } cfg_t;

    typedef struct packed {
        logic [ROW_SUM_W-1:0] row_sum;
        logic [HIT_W-1:0]     hit_count;
    } frame_sum_t;

    typedef struct packed {
        logic [IAVG_W-1:0] interval_average;
        logic              interval_valid;
        logic              minimum_marked;
        logic              average_valid;
        logic [AVG_W-1:0]  frame_average;
    } result_t;

    function automatic logic chan_match(
        input logic [PIX_W-1:0] p,
        input logic [PIX_W-1:0] t,
        input logic [PIX_W-1:0] tol
    );
        logic [PIX_W-1:0] diff;
        begin
            diff = (p > t) ? (p - t) : (t - p);
            return diff <= tol;
        end
    endfunction

endpackage

// File: sv/color_edge_height_beat_tracker.sv
// Pixels: one per cycle while s_tready is high; each is held in s1 before the column tag write.
// Frame result: after the last pixel is accepted it is computed by up to two runs of the
// bit-serial divider (mean row, then mean mark interval); a run is skipped for a zero divisor.
// An end-of-frame pixel waits until the previous frame's result is in the output register.
// Reset: after rst_n is released the column tag memory is cleared one entry per cycle,
// all MAX_WIDTH entries, with s_tready low; configuration writes are taken throughout.
module color_edge_height_beat_tracker #(
    parameter int MAX_WIDTH        = cehbt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT       = cehbt_pkg::MAX_HEIGHT_DEF,
    parameter int FRAME_INDEX_BITS = cehbt_pkg::FRAME_INDEX_BITS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cehbt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cehbt_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cehbt_pkg::S_TDATA_W-1:0]    s_tdata,   // red, green, blue
    input  logic                               s_tlast,   // end_of_frame

    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cehbt_pkg::M_TDATA_W-1:0]    m_tdata,   // frame_average, interval_average, pad
    output logic [cehbt_pkg::M_TUSER_W-1:0]    m_tuser    // average_valid, minimum_marked,
                                                          // interval_valid
);

    localparam int PW = cehbt_pkg::PIX_W;

    cehbt_pkg::cfg_t       cfg_reg;
    cehbt_pkg::frame_sum_t frame_sum;
    cehbt_pkg::result_t    fe_result;
    cehbt_pkg::result_t    out_reg;
    logic                  out_valid_reg;

    logic frame_done;
    logic fe_busy;
    logic fe_load;
    logic slot_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_red   <= '0;
            cfg_reg.target_green <= '0;
            cfg_reg.target_blue  <= '0;
            cfg_reg.tolerance    <= cehbt_pkg::TOLERANCE_RESET;
            cfg_reg.frame_width  <= cehbt_pkg::FRAME_WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cehbt_pkg::REG_TARGET_RED:   cfg_reg.target_red   <= cfg_data[PW-1:0];
                cehbt_pkg::REG_TARGET_GREEN: cfg_reg.target_green <= cfg_data[PW-1:0];
                cehbt_pkg::REG_TARGET_BLUE:  cfg_reg.target_blue  <= cfg_data[PW-1:0];
                cehbt_pkg::REG_TOLERANCE:    cfg_reg.tolerance    <= cfg_data[PW-1:0];
                cehbt_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    cehbt_column_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .fe_busy    (fe_busy),
        .frame_done (frame_done),
        .frame_sum  (frame_sum)
    );

    cehbt_frame_end #(
        .FRAME_INDEX_BITS (FRAME_INDEX_BITS)
    ) u_frame_end
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (frame_done),
        .frame_sum (frame_sum),
        .busy      (fe_busy),
        .slot_free (slot_free),
        .load      (fe_load),
        .result    (fe_result)
    );

    // output register: hold until the downstream transaction completes
    assign slot_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fe_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe_load)
        begin
            out_reg <= fe_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cehbt_pkg::M_TDATA_W'({out_reg.interval_average, out_reg.frame_average});
    assign m_tuser  = {out_reg.interval_valid, out_reg.minimum_marked, out_reg.average_valid};

endmodule

// File: sv/cehbt_divider.sv
module cehbt_divider
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [cehbt_pkg::DVD_W-1:0]   dividend,
    input  logic [cehbt_pkg::DVS_W-1:0]   divisor,
    output logic                          done,
    output logic [cehbt_pkg::DVD_W-1:0]   quotient
);

    localparam int DW     = cehbt_pkg::DVD_W;
    localparam int SW     = cehbt_pkg::DVS_W;
    localparam int STEP_W = $clog2(DW);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SW-1:0]     rem_reg;
    logic [SW-1:0]     dvs_reg;
    logic [DW-1:0]     quo_reg;

    logic [SW:0] rem_shift;
    logic [SW:0] rem_sub;
    logic        ge;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DW-1]};
        ge        = rem_shift >= {1'b0, dvs_reg};
        rem_sub   = ge ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == STEP_W'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= rem_sub[SW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/cehbt_frame_end.sv
module cehbt_frame_end #(
    parameter int FRAME_INDEX_BITS = cehbt_pkg::FRAME_INDEX_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  cehbt_pkg::frame_sum_t   frame_sum,
    output logic                    busy,
    input  logic                    slot_free,
    output logic                    load,
    output cehbt_pkg::result_t      result
);

    localparam int FIB = FRAME_INDEX_BITS;
    localparam int SW  = ((FIB > cehbt_pkg::ISUM_W) ? FIB : cehbt_pkg::ISUM_W) + 1;
    localparam int DW  = cehbt_pkg::DVD_W;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DIV_AVG = 3'd1;
    localparam logic [2:0] ST_TREND   = 3'd2;
    localparam logic [2:0] ST_DIV_INT = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    localparam logic [cehbt_pkg::ISUM_W-1:0] ISUM_MAX = '1;
    localparam logic [cehbt_pkg::ICNT_W-1:0] ICNT_MAX = '1;

    logic [2:0] state_reg, state_next;

    logic [cehbt_pkg::AVG_W-1:0]  avg_reg;
    logic                         avg_valid_reg;
    logic                         marked_reg;
    logic [cehbt_pkg::IAVG_W-1:0] iavg_reg;
    logic [cehbt_pkg::AVG_W-1:0]  prev_avg_reg;
    logic                         prev_valid_reg;
    logic                         falling_reg;
    logic [FIB-1:0]               frame_idx_reg;
    logic [FIB-1:0]               last_mark_reg;
    logic                         mark_seen_reg;
    logic [cehbt_pkg::ISUM_W-1:0] isum_reg;
    logic [cehbt_pkg::ICNT_W-1:0] icnt_reg;

    logic                         compare_ok;
    logic                         mark;
    logic                         falling_next;
    logic [FIB-1:0]               gap;
    logic [SW-1:0]                gap_sum;
    logic [cehbt_pkg::ISUM_W-1:0] isum_next;
    logic [cehbt_pkg::ICNT_W-1:0] icnt_next;

    logic                          div_start;
    logic [DW-1:0]                 div_dividend;
    logic [cehbt_pkg::DVS_W-1:0]   div_divisor;
    logic                          div_done;
    logic [DW-1:0]                 div_quotient;

    always_comb
    begin
        compare_ok   = avg_valid_reg && prev_valid_reg;
        mark         = compare_ok && (avg_reg < prev_avg_reg) && !falling_reg;
        falling_next = falling_reg;
        if (mark)
        begin
            falling_next = 1'b1;
        end
        else if (compare_ok && (avg_reg > prev_avg_reg))
        begin
            falling_next = 1'b0;
        end

        gap       = frame_idx_reg - last_mark_reg;
        gap_sum   = SW'(isum_reg) + SW'(gap);
        isum_next = isum_reg;
        icnt_next = icnt_reg;
        if (mark && mark_seen_reg && (icnt_reg != ICNT_MAX))
        begin
            isum_next = (gap_sum > SW'(ISUM_MAX)) ? ISUM_MAX : gap_sum[cehbt_pkg::ISUM_W-1:0];
            icnt_next = icnt_reg + 1'b1;
        end
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = {frame_sum.row_sum, {cehbt_pkg::FRAC_W{1'b0}}};
        div_divisor  = cehbt_pkg::DVS_W'(frame_sum.hit_count);
        state_next   = state_reg;
        load         = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    div_start  = (frame_sum.hit_count != '0);
                    state_next = (frame_sum.hit_count != '0) ? ST_DIV_AVG : ST_TREND;
                end
            end
            ST_DIV_AVG:
            begin
                if (div_done)
                begin
                    state_next = ST_TREND;
                end
            end
            ST_TREND:
            begin
                div_start    = (icnt_next != '0);
                div_dividend = DW'({isum_next, {cehbt_pkg::FRAC_W{1'b0}}});
                div_divisor  = icnt_next;
                state_next   = (icnt_next != '0) ? ST_DIV_INT : ST_DONE;
            end
            ST_DIV_INT:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            prev_avg_reg   <= '0;
            prev_valid_reg <= 1'b0;
            falling_reg    <= 1'b0;
            frame_idx_reg  <= '0;
            last_mark_reg  <= '0;
            mark_seen_reg  <= 1'b0;
            isum_reg       <= '0;
            icnt_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_TREND)
            begin
                prev_avg_reg   <= avg_reg;
                prev_valid_reg <= avg_valid_reg;
                falling_reg    <= falling_next;
                frame_idx_reg  <= frame_idx_reg + 1'b1;
                isum_reg       <= isum_next;
                icnt_reg       <= icnt_next;
                if (mark)
                begin
                    last_mark_reg <= frame_idx_reg;
                    mark_seen_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start && (frame_sum.hit_count == '0))
        begin
            avg_reg       <= '0;
            avg_valid_reg <= 1'b0;
        end
        if ((state_reg == ST_DIV_AVG) && div_done)
        begin
            avg_reg       <= div_quotient[cehbt_pkg::AVG_W-1:0];
            avg_valid_reg <= 1'b1;
        end
        if (state_reg == ST_TREND)
        begin
            marked_reg <= mark;
            if (icnt_next == '0)
            begin
                iavg_reg <= '0;
            end
        end
        if ((state_reg == ST_DIV_INT) && div_done)
        begin
            iavg_reg <= div_quotient[cehbt_pkg::IAVG_W-1:0];
        end
    end

    cehbt_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign busy = (state_reg != ST_IDLE);

    always_comb
    begin
        result.frame_average    = avg_reg;
        result.average_valid    = avg_valid_reg;
        result.minimum_marked   = marked_reg;
        result.interval_average = iavg_reg;
        result.interval_valid   = (icnt_reg != '0);
    end

endmodule

// File: sv/cehbt_column_scan.sv
module cehbt_column_scan #(
    parameter int MAX_WIDTH  = cehbt_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cehbt_pkg::MAX_HEIGHT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  cehbt_pkg::cfg_t                   cfg,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cehbt_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                              s_tlast,
    input  logic                              fe_busy,
    output logic                              frame_done,
    output cehbt_pkg::frame_sum_t             frame_sum
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CMP_W = ((CW + 1) > cehbt_pkg::FW_W) ? (CW + 1) : cehbt_pkg::FW_W;

    localparam int PW = cehbt_pkg::PIX_W;

    logic tag_mem [MAX_WIDTH];

    logic          clearing_reg;
    logic [CW-1:0] clr_cnt_reg;

    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;

    logic          s1_valid_reg;
    logic          s1_hit_reg;
    logic          s1_eof_reg;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic          tag_rd_reg;
    logic          fwd_sel_reg;
    logic          fwd_bit_reg;

    logic                            parity_reg;
    logic [cehbt_pkg::ROW_SUM_W-1:0] row_sum_reg, row_sum_next;
    logic [cehbt_pkg::HIT_W-1:0]     hit_cnt_reg, hit_cnt_next;

    logic             accept;
    logic             s1_fire;
    logic             pix_hit;
    logic [CMP_W-1:0] w_ext;
    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] col_inc;
    logic             wrap;

    logic          tag_cur;
    logic          s1_we;
    logic          s1_wd;
    logic          mem_we;
    logic [CW-1:0] mem_wa;
    logic          mem_wd;

    assign s1_fire  = s1_valid_reg && !(s1_eof_reg && fe_busy);
    assign s_tready = !clearing_reg && (!s1_valid_reg || s1_fire);
    assign accept   = s_tvalid && s_tready;

    assign pix_hit = cehbt_pkg::chan_match(s_tdata[PW-1:0], cfg.target_red, cfg.tolerance)
                  && cehbt_pkg::chan_match(s_tdata[2*PW-1:PW], cfg.target_green, cfg.tolerance)
                  && cehbt_pkg::chan_match(s_tdata[3*PW-1:2*PW], cfg.target_blue, cfg.tolerance);

    always_comb
    begin
        w_ext = CMP_W'(cfg.frame_width);
        if (w_ext == '0)
        begin
            w_eff = CMP_W'(1);
        end
        else if (w_ext > CMP_W'(MAX_WIDTH))
        begin
            w_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
        col_inc = CMP_W'(col_reg) + 1'b1;
        wrap    = col_inc >= w_eff;
    end

    // raster position of the next pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (s_tlast)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (wrap)
            begin
                col_reg <= '0;
                if (row_reg != RW'(MAX_HEIGHT - 1))
                begin
                    row_reg <= row_reg + 1'b1;
                end
            end
            else
            begin
                col_reg <= col_inc[CW-1:0];
            end
        end
    end

    // first-hit update of the column tag and the frame accumulators
    always_comb
    begin
        tag_cur      = fwd_sel_reg ? fwd_bit_reg : tag_rd_reg;
        s1_we        = 1'b0;
        s1_wd        = parity_reg;
        row_sum_next = row_sum_reg;
        hit_cnt_next = hit_cnt_reg;
        if (s1_valid_reg)
        begin
            if (s1_row_reg == '0)
            begin
                s1_we = 1'b1;
                s1_wd = s1_hit_reg ? parity_reg : !parity_reg;
                if (s1_hit_reg)
                begin
                    hit_cnt_next = hit_cnt_reg + 1'b1;
                end
            end
            else if (s1_hit_reg && (tag_cur != parity_reg))
            begin
                s1_we        = 1'b1;
                row_sum_next = row_sum_reg + cehbt_pkg::ROW_SUM_W'(s1_row_reg);
                hit_cnt_next = hit_cnt_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            mem_we = 1'b1;
            mem_wa = clr_cnt_reg;
            mem_wd = 1'b0;
        end
        else
        begin
            mem_we = s1_we && s1_fire;
            mem_wa = s1_col_reg;
            mem_wd = s1_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[mem_wa] <= mem_wd;
        end
        if (accept)
        begin
            tag_rd_reg <= tag_mem[col_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            if (clr_cnt_reg == CW'(MAX_WIDTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            parity_reg   <= 1'b1;
            row_sum_reg  <= '0;
            hit_cnt_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                if (s1_eof_reg)
                begin
                    parity_reg  <= !parity_reg;
                    row_sum_reg <= '0;
                    hit_cnt_reg <= '0;
                end
                else
                begin
                    row_sum_reg <= row_sum_next;
                    hit_cnt_reg <= hit_cnt_next;
                end
            end
        end
    end

    // a write landing in the same cycle as the read of that column is forwarded
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hit_reg  <= pix_hit;
            s1_eof_reg  <= s_tlast;
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            fwd_sel_reg <= s1_fire && s1_we && (s1_col_reg == col_reg);
            fwd_bit_reg <= s1_wd;
        end
    end

    assign frame_done          = s1_fire && s1_eof_reg;
    assign frame_sum.row_sum   = row_sum_next;
    assign frame_sum.hit_count = hit_cnt_next;

endmodule

// File: dv/beat_tracker_monitor.sv
`timescale 1ns / 100ps

module beat_tracker_monitor
(
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [cehbt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cehbt_pkg::CFG_DATA_W-1:0] cfg_data,

    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [cehbt_pkg::S_TDATA_W-1:0]  s_tdata,   // red, green, blue
    input  logic                             s_tlast,   // end_of_frame

    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [cehbt_pkg::M_TDATA_W-1:0]  m_tdata,   // frame_average, interval_average, pad
    input  logic [cehbt_pkg::M_TUSER_W-1:0]  m_tuser,   // average_valid, minimum_marked,
                                                        // interval_valid

    output int                               mismatch_count,
    output int                               frames_pending
);

    localparam int COLS     = cehbt_pkg::MAX_WIDTH_DEF;
    localparam int LAST_ROW = cehbt_pkg::MAX_HEIGHT_DEF - 1;

    cehbt_pkg::cfg_t                                 cfg;
    logic                                            col_tag [COLS];
    logic                                            parity;
    logic [$clog2(cehbt_pkg::MAX_WIDTH_DEF)-1:0]     col_pos;
    logic [$clog2(cehbt_pkg::MAX_HEIGHT_DEF)-1:0]    row_pos;
    logic [cehbt_pkg::ROW_SUM_W-1:0]                 row_sum;
    logic [cehbt_pkg::HIT_W-1:0]                     hit_count;
    logic [cehbt_pkg::AVG_W-1:0]                     prev_avg;
    logic                                            prev_valid;
    logic                                            falling;
    logic                                            mark_seen;
    logic [cehbt_pkg::FRAME_INDEX_BITS_DEF-1:0]      frame_idx;
    logic [cehbt_pkg::FRAME_INDEX_BITS_DEF-1:0]      last_mark;
    logic [cehbt_pkg::ISUM_W-1:0]                    gap_sum;
    logic [cehbt_pkg::ICNT_W-1:0]                    gap_count;

    cehbt_pkg::result_t expected_frames [$];
    cehbt_pkg::result_t want;

    function automatic logic close_enough(input logic [cehbt_pkg::PIX_W-1:0] a,
                                          input logic [cehbt_pkg::PIX_W-1:0] b);
        logic [cehbt_pkg::PIX_W-1:0] spread;
        spread = (a > b) ? a - b : b - a;
        return spread <= cfg.tolerance;
    endfunction

    task automatic check_field(input string what, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, what, exp_val, act_val);
        end
    endtask

    // Update the tracker state with one pixel; queue a frame result on end of frame.
    task automatic take_pixel(input logic [cehbt_pkg::S_TDATA_W-1:0] pix, input logic eof);
        int                                                  cols;
        int                                                  col;
        logic                                                hit;
        logic [cehbt_pkg::DVD_W-1:0]                         row_quot;
        logic [cehbt_pkg::ISUM_W+cehbt_pkg::FRAC_W-1:0]      gap_quot;
        logic [cehbt_pkg::ISUM_W:0]                          sum_ext;
        logic [cehbt_pkg::FRAME_INDEX_BITS_DEF-1:0]          gap;
        cehbt_pkg::result_t                                  res;

        cols = (cfg.frame_width == 0) ? 1 :
               (cfg.frame_width > COLS) ? COLS : int'(cfg.frame_width);
        col = int'(col_pos);
        hit = close_enough(pix[cehbt_pkg::PIX_W-1:0], cfg.target_red) &&
              close_enough(pix[2*cehbt_pkg::PIX_W-1:cehbt_pkg::PIX_W], cfg.target_green) &&
              close_enough(pix[3*cehbt_pkg::PIX_W-1:2*cehbt_pkg::PIX_W], cfg.target_blue);

        // row 0 rewrites every tag it visits, so a column visited in row 0 carries no stale tag
        if (row_pos == 0)
        begin
            col_tag[col] = hit ? parity : ~parity;
            if (hit)
                hit_count++;
        end
        else if (hit && col_tag[col] != parity)
        begin
            col_tag[col] = parity;
            row_sum += cehbt_pkg::ROW_SUM_W'(row_pos);
            hit_count++;
        end

        if (col + 1 >= cols)
        begin
            col_pos = '0;
            if (row_pos < LAST_ROW)
                row_pos++;
        end
        else
            col_pos++;

        if (!eof)
            return;

        res = '0;
        if (hit_count != 0)
        begin
            row_quot = {row_sum, {cehbt_pkg::FRAC_W{1'b0}}} / hit_count;
            res.frame_average = row_quot[cehbt_pkg::AVG_W-1:0];
            res.average_valid = 1'b1;
        end

        if (res.average_valid && prev_valid)
        begin
            if (res.frame_average < prev_avg && !falling)
            begin
                res.minimum_marked = 1'b1;
                falling = 1'b1;
                if (!mark_seen)
                    mark_seen = 1'b1;
                else if (gap_count != '1)
                begin
                    gap = frame_idx - last_mark;
                    sum_ext = {1'b0, gap_sum} + {1'b0, gap};
                    gap_sum = sum_ext[cehbt_pkg::ISUM_W] ? '1 : sum_ext[cehbt_pkg::ISUM_W-1:0];
                    gap_count++;
                end
                last_mark = frame_idx;
            end
            if (res.frame_average > prev_avg && falling)
                falling = 1'b0;
        end

        if (gap_count != 0)
        begin
            gap_quot = {gap_sum, {cehbt_pkg::FRAC_W{1'b0}}} / gap_count;
            res.interval_average = gap_quot;
            res.interval_valid = 1'b1;
        end

        prev_avg = res.frame_average;
        prev_valid = res.average_valid;
        frame_idx++;
        parity = ~parity;
        col_pos = '0;
        row_pos = '0;
        row_sum = '0;
        hit_count = '0;
        expected_frames.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg = '0;
            cfg.tolerance = cehbt_pkg::TOLERANCE_RESET;
            cfg.frame_width = cehbt_pkg::FRAME_WIDTH_RESET;
            foreach (col_tag[i])
                col_tag[i] = 1'b0;
            parity = 1'b1;
            col_pos = '0;
            row_pos = '0;
            row_sum = '0;
            hit_count = '0;
            prev_avg = '0;
            prev_valid = 1'b0;
            falling = 1'b0;
            mark_seen = 1'b0;
            frame_idx = '0;
            last_mark = '0;
            gap_sum = '0;
            gap_count = '0;
            expected_frames.delete();
            mismatch_count = 0;
            frames_pending = 0;
        end
        else
        begin
            // check the outgoing transaction before queueing anything new
            if (m_tvalid && m_tready)
            begin
                if (expected_frames.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with no frame pending, tdata %h tuser %h",
                             $time, m_tdata, m_tuser);
                end
                else
                begin
                    want = expected_frames.pop_front();
                    check_field("frame_average", 32'(want.frame_average),
                                32'(m_tdata[cehbt_pkg::AVG_W-1:0]));
                    check_field("interval_average", 32'(want.interval_average),
                                32'(m_tdata[cehbt_pkg::AVG_W+cehbt_pkg::IAVG_W-1:
                                            cehbt_pkg::AVG_W]));
                    check_field("average_valid", 32'(want.average_valid), 32'(m_tuser[0]));
                    check_field("minimum_marked", 32'(want.minimum_marked), 32'(m_tuser[1]));
                    check_field("interval_valid", 32'(want.interval_valid), 32'(m_tuser[2]));
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cehbt_pkg::REG_TARGET_RED:
                        cfg.target_red = cfg_data[cehbt_pkg::PIX_W-1:0];
                    cehbt_pkg::REG_TARGET_GREEN:
                        cfg.target_green = cfg_data[cehbt_pkg::PIX_W-1:0];
                    cehbt_pkg::REG_TARGET_BLUE:
                        cfg.target_blue = cfg_data[cehbt_pkg::PIX_W-1:0];
                    cehbt_pkg::REG_TOLERANCE:
                        cfg.tolerance = cfg_data[cehbt_pkg::PIX_W-1:0];
                    cehbt_pkg::REG_FRAME_WIDTH:
                        cfg.frame_width = cfg_data[cehbt_pkg::FW_W-1:0];
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready)
                take_pixel(s_tdata, s_tlast);

            frames_pending = expected_frames.size();
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int SETTLE_CYCLES = 80;
    localparam int STUCK_LIMIT   = 4000;
    localparam int NOISE_PCT     = 10;
    localparam int SHORT_FRAME   = 40;
    localparam int PIX_MAX       = (1 << cehbt_pkg::PIX_W) - 1;

    localparam logic [cehbt_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST =
        cehbt_pkg::REG_FRAME_WIDTH + 1'b1;
    localparam logic [cehbt_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;

    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [cehbt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cehbt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [cehbt_pkg::S_TDATA_W-1:0]  s_tdata = '0;
    logic                             s_tlast = 1'b0;

    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [cehbt_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [cehbt_pkg::M_TUSER_W-1:0]  m_tuser;

    int                               mismatch_count;
    int                               frames_pending;

    int                               send_idle_pct = 0;
    int                               stall_pct = 0;

    // generator's view of the programmed color window and row length
    logic [cehbt_pkg::PIX_W-1:0]      aim_red = '0;
    logic [cehbt_pkg::PIX_W-1:0]      aim_green = '0;
    logic [cehbt_pkg::PIX_W-1:0]      aim_blue = '0;
    logic [cehbt_pkg::PIX_W-1:0]      aim_tol = cehbt_pkg::TOLERANCE_RESET;
    int                               row_len = cehbt_pkg::MAX_WIDTH_DEF;

    always #10 clk = ~clk;

    color_edge_height_beat_tracker DUT (.*);

    beat_tracker_monitor monitor (.*);

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    initial
    begin : watchdog
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("FAIL color_edge_height_beat_tracker");
        $finish;
    end

    function automatic logic [cehbt_pkg::CFG_DATA_W-1:0] rand_value();
        return cehbt_pkg::CFG_DATA_W'($urandom);
    endfunction

    function automatic logic [cehbt_pkg::S_TDATA_W-1:0] match_pixel();
        logic [cehbt_pkg::PIX_W-1:0] aim [3];
        logic [cehbt_pkg::PIX_W-1:0] chan [3];
        int                          lo;
        int                          hi;
        aim = '{aim_red, aim_green, aim_blue};
        for (int i = 0; i < 3; i++)
        begin
            lo = int'(aim[i]) - int'(aim_tol);
            hi = int'(aim[i]) + int'(aim_tol);
            if (lo < 0)
                lo = 0;
            if (hi > PIX_MAX)
                hi = PIX_MAX;
            chan[i] = cehbt_pkg::PIX_W'($urandom_range(hi, lo));
        end
        return {chan[2], chan[1], chan[0]};
    endfunction

    // Push one channel outside the window, if the window leaves room for it.
    function automatic logic [cehbt_pkg::S_TDATA_W-1:0] miss_pixel();
        logic [cehbt_pkg::S_TDATA_W-1:0] pix;
        logic [cehbt_pkg::PIX_W-1:0]     aim;
        int                              chan;
        int                              above;
        int                              below;
        pix = cehbt_pkg::S_TDATA_W'($urandom);
        chan = $urandom_range(0, 2);
        aim = (chan == 0) ? aim_red : (chan == 1) ? aim_green : aim_blue;
        above = int'(aim) + int'(aim_tol) + 1;
        below = int'(aim) - int'(aim_tol) - 1;
        if (above <= PIX_MAX && (below < 0 || $urandom_range(0, 1) == 1))
            pix[chan*cehbt_pkg::PIX_W +: cehbt_pkg::PIX_W] =
                cehbt_pkg::PIX_W'($urandom_range(PIX_MAX, above));
        else if (below >= 0)
            pix[chan*cehbt_pkg::PIX_W +: cehbt_pkg::PIX_W] =
                cehbt_pkg::PIX_W'($urandom_range(below, 0));
        return pix;
    endfunction

    task automatic push_pixel(input logic [cehbt_pkg::S_TDATA_W-1:0] pix, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
    endtask

    // Leaves cfg_valid high; the caller drops it after the last write.
    task automatic write_reg(input logic [cehbt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cehbt_pkg::CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic set_config(input logic [cehbt_pkg::CFG_DATA_W-1:0] red,
                              input logic [cehbt_pkg::CFG_DATA_W-1:0] green,
                              input logic [cehbt_pkg::CFG_DATA_W-1:0] blue,
                              input logic [cehbt_pkg::CFG_DATA_W-1:0] tol,
                              input logic [cehbt_pkg::CFG_DATA_W-1:0] width);
        // an unmapped index must leave every register alone
        write_reg(cehbt_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                  rand_value());
        write_reg(cehbt_pkg::REG_TARGET_RED, red);
        write_reg(cehbt_pkg::REG_TARGET_GREEN, green);
        write_reg(cehbt_pkg::REG_TARGET_BLUE, blue);
        write_reg(cehbt_pkg::REG_TOLERANCE, tol);
        write_reg(cehbt_pkg::REG_FRAME_WIDTH, width);
        cfg_valid <= 1'b0;
        aim_red = red[cehbt_pkg::PIX_W-1:0];
        aim_green = green[cehbt_pkg::PIX_W-1:0];
        aim_blue = blue[cehbt_pkg::PIX_W-1:0];
        aim_tol = tol[cehbt_pkg::PIX_W-1:0];
        row_len = (width == 0) ? 1 :
                  (width > cehbt_pkg::MAX_WIDTH_DEF) ? cehbt_pkg::MAX_WIDTH_DEF : int'(width);
    endtask

    // Drain all pending frame results, then let the pipeline go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (frames_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Each column gets a first-hit row or none; noise aside, pixels above miss, below mix.
    task automatic send_frame(input int rows, input int count, input bit blank);
        int                              first_row [cehbt_pkg::MAX_WIDTH_DEF];
        int                              n;
        int                              col;
        int                              row;
        logic [cehbt_pkg::S_TDATA_W-1:0] pix;
        for (col = 0; col < row_len; col++)
            first_row[col] = (blank || $urandom_range(0, 4) == 0) ? -1 :
                             int'($urandom_range(0, rows - 1));
        for (n = 0; n < count; n++)
        begin
            col = n % row_len;
            row = n / row_len;
            if ($urandom_range(0, 99) < NOISE_PCT)
                pix = cehbt_pkg::S_TDATA_W'($urandom);
            else if (first_row[col] >= 0 &&
                     (row == first_row[col] ||
                      (row > first_row[col] && $urandom_range(0, 1) == 1)))
                pix = match_pixel();
            else
                pix = miss_pixel();
            push_pixel(pix, n == count - 1);
        end
    endtask

    task automatic run_phase(input int idle, input int stall,
                             input logic [cehbt_pkg::CFG_DATA_W-1:0] red,
                             input logic [cehbt_pkg::CFG_DATA_W-1:0] green,
                             input logic [cehbt_pkg::CFG_DATA_W-1:0] blue,
                             input logic [cehbt_pkg::CFG_DATA_W-1:0] tol,
                             input logic [cehbt_pkg::CFG_DATA_W-1:0] width,
                             input int item_goal, input int max_rows);
        int sent;
        int frames;
        int rows;
        int count;
        settle();
        send_idle_pct = idle;
        stall_pct = stall;
        set_config(red, green, blue, tol, width);
        sent = 0;
        frames = 0;
        while (sent < item_goal || frames < 12)
        begin
            rows = $urandom_range(1, max_rows);
            count = rows * row_len;
            // cut some frames short or let them spill into a partial row
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, count + row_len);
            send_frame(rows, count, $urandom_range(0, 9) == 0);
            sent += count;
            frames++;
        end
    endtask

    initial
    begin
        int first_hits [9];
        int k;

        first_hits = '{1, 3, 0, 2, 0, -1, 2, 1, 1};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: black target, full-width rows
        push_pixel({cehbt_pkg::S_TDATA_W{1'b0}}, 1'b1);
        push_pixel({cehbt_pkg::S_TDATA_W{1'b1}}, 1'b1);

        // width 0 acts as one column, so each pixel is a row; walk rise/fall/flat patterns
        settle();
        set_config('0, '0, '0, '0, '0);
        foreach (first_hits[i])
        begin
            for (k = 0; k < first_hits[i]; k++)
                push_pixel(miss_pixel(), 1'b0);
            push_pixel((first_hits[i] < 0) ? miss_pixel() : match_pixel(), 1'b1);
        end

        run_phase(65, 0, 11'h7FF, 11'h000, 11'h0FF, 11'd0, 11'd4, 150, 4);
        run_phase(0, 65, rand_value(), rand_value(), rand_value(), 11'd40, 11'd2, 150, 5);
        run_phase(16, 16, rand_value(), rand_value(), rand_value(), 11'd255, 11'd3, 60, 3);
        run_phase(0, 0, rand_value(), rand_value(), rand_value(), 11'd20, 11'd6, 150, 3);

        // width above range clamps to full rows; one short frame
        settle();
        send_idle_pct = 0;
        stall_pct = 0;
        set_config(rand_value(), rand_value(), rand_value(), 11'd30, 11'h7FF);
        send_frame(1, SHORT_FRAME, 1'b0);

        run_phase(16, 16, rand_value(), rand_value(), rand_value(),
                  cehbt_pkg::CFG_DATA_W'($urandom_range(10, 80)), 11'd5, 200, 4);

        settle();
        if (mismatch_count == 0 && frames_pending == 0)
            $display("PASS color_edge_height_beat_tracker");
        else
            $display("FAIL color_edge_height_beat_tracker");
        $finish;
    end

endmodule
